### hdl/c2s_pkg.sv
`default_nettype none
package c2s_pkg;

   // CORDIC word, angle accumulator and rotation count.
   localparam int CORDIC_WIDTH = 64;
   localparam int ACC_WIDTH    = 36;
   localparam int CORDIC_STEPS = 31;

   // Angles in Q.30 radians.
   localparam longint PI_Q30            = 64'sd3373259426;
   localparam longint THREE_HALF_PI_Q30 = 64'sd5059889139;
   localparam longint TWO_PI_Q30        = 64'sd6746518852;

   // Operands are doubled until the larger magnitude reaches 2^57.
   localparam logic [CORDIC_WIDTH-1:0] NORM_LIMIT   = 64'h0200_0000_0000_0000;
   localparam logic [CORDIC_WIDTH-1:0] COARSE_LIMIT = 64'h0002_0000_0000_0000;

   // atan(2^-i) in Q.30, truncated.
   localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
      30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
      30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
      30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
      30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
      30'd127, 30'd63, 30'd31, 30'd15, 30'd7, 30'd3, 30'd1, 30'd0
   };

   // Rounds a Q.30 angle to frac_bits fraction bits.
   function automatic longint to_frac(input longint q30, input int frac_bits);
      return (q30 + (longint'(1) <<< (29 - frac_bits))) >>> (30 - frac_bits);
   endfunction

   typedef struct packed {
      logic load;
      logic square;
      logic sum;
      logic start_root;
      logic start_az;
      logic keep_az;
      logic start_pol;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic root_idle;
      logic cordic_idle;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

### hdl/cartesian_to_spherical_unwrap.sv
// Converts lidar points from Cartesian millimetres to range, polar angle and
// unwrapped azimuth, with angles in radians scaled by 2^ANGLE_FRAC_BITS. One
// point is processed at a time: after a transfer on the request channel the
// block computes the squares and their sums, then runs two bit-serial square
// roots alongside the azimuth CORDIC, and then the polar CORDIC on the same
// unit. Each CORDIC pass on a nonzero vector normalizes its operands and then
// runs the rotations. The time per item is set by the planar square root
// followed by the shared CORDIC unit. The result waits in an output register,
// so a new request transfer is taken as soon as the previous point has been
// written there. The azimuth is unwrapped against the previous result unless
// first_point is set, and saturates with a flag.
`default_nettype none
module cartesian_to_spherical_unwrap
   import c2s_pkg::*;
#(
   parameter int COORD_WIDTH     = 20,
   parameter int ANGLE_FRAC_BITS = 13
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [COORD_WIDTH-1:0]       req_x_mm,
   input  wire logic signed [COORD_WIDTH-1:0]       req_y_mm,
   input  wire logic signed [COORD_WIDTH-1:0]       req_z_mm,
   input  wire logic                                req_first_point,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [COORD_WIDTH-1:0]                   rsp_range_mm,
   output logic [ANGLE_FRAC_BITS+1:0]               rsp_polar_angle,
   output logic signed [ANGLE_FRAC_BITS+5:0]        rsp_azimuth,
   output logic                                     rsp_azimuth_saturated
);
   localparam logic [ANGLE_FRAC_BITS+1:0] POLAR_MAX =
      (ANGLE_FRAC_BITS+2)'(to_frac(PI_Q30, ANGLE_FRAC_BITS));
   localparam logic signed [ANGLE_FRAC_BITS+5:0] AZ_HI =
      (ANGLE_FRAC_BITS+6)'((longint'(1) <<< (ANGLE_FRAC_BITS + 5)) - 1);
   localparam logic signed [ANGLE_FRAC_BITS+5:0] AZ_LO = ~AZ_HI;

   // Commands from the controller and status from the datapath.
   cmd_type    cmd;
   status_type status;

   c2s_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   c2s_datapath #(
      .W (COORD_WIDTH),
      .F (ANGLE_FRAC_BITS)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .req_x_mm              (req_x_mm),
      .req_y_mm              (req_y_mm),
      .req_z_mm              (req_z_mm),
      .req_first_point       (req_first_point),
      .cmd                   (cmd),
      .status                (status),
      .rsp_stall             (rsp_stall),
      .rsp_valid             (rsp_valid),
      .rsp_range_mm          (rsp_range_mm),
      .rsp_polar_angle       (rsp_polar_angle),
      .rsp_azimuth           (rsp_azimuth),
      .rsp_azimuth_saturated (rsp_azimuth_saturated)
   );

`ifndef SYNTHESIS
   // Only one point is in flight: a request transfer closes the input side.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while a point is in flight");

   // The saturation flag only accompanies an azimuth at a field limit.
   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_azimuth_saturated |-> rsp_azimuth == AZ_HI || rsp_azimuth == AZ_LO)
      else $error("saturation flag without clamped azimuth");

   // The polar angle never exceeds pi.
   a_polar_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_polar_angle <= POLAR_MAX)
      else $error("polar angle above pi");
`endif
endmodule
`default_nettype wire

### hdl/c2s_sqrt.sv
`default_nettype none
module c2s_sqrt #(
   parameter int RW = 40
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic [RW-1:0]   radicand,
   output logic                 idle,
   output logic [RW/2-1:0]      root,
   output logic [RW/2+1:0]      rem
);
   localparam int HW    = RW / 2;
   localparam int CNT_W = $clog2(HW + 1);

   logic [RW-1:0]    rad_ff, rad_in;
   logic [HW-1:0]    root_ff, root_in;
   logic [HW+1:0]    rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [HW+1:0]    rem_sh, trial;
   logic             ge;

   // Restoring square root, one result bit per cycle.
   always_comb begin
      rem_sh  = {rem_ff[HW-1:0], rad_ff[RW-1:RW-2]};
      trial   = {root_ff, 2'b01};
      ge      = rem_sh >= trial;
      rad_in  = rad_ff;
      root_in = root_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rad_in  = radicand;
         root_in = '0;
         rem_in  = '0;
         cnt_in  = CNT_W'(HW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[RW-3:0], 2'b00};
         rem_in  = ge ? rem_sh - trial : rem_sh;
         root_in = {root_ff[HW-2:0], ge};
         cnt_in  = cnt_ff - CNT_W'(1);
         busy_in = cnt_ff != CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign idle = !busy_ff;
   assign root = root_ff;
   assign rem  = rem_ff;
endmodule
`default_nettype wire

### hdl/c2s_cordic.sv
`default_nettype none
module c2s_cordic
   import c2s_pkg::*;
#(
   parameter int F = 13
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic signed [CORDIC_WIDTH-1:0] y_in,
   input  wire logic signed [CORDIC_WIDTH-1:0] x_in,
   output logic                                idle,
   output logic signed [F+2:0]                 result
);
   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_NORM = 3'b010,
      PH_ROT  = 3'b100
   } phase_type;

   localparam logic signed [ACC_WIDTH-1:0] PI_A  = ACC_WIDTH'(PI_Q30);
   localparam logic signed [ACC_WIDTH-1:0] RND_A = ACC_WIDTH'(longint'(1) <<< (29 - F));

   phase_type                      phase_ff, phase_in;
   logic signed [CORDIC_WIDTH-1:0] x_ff, x_in_r, y_ff, y_in_r;
   logic signed [ACC_WIDTH-1:0]    ang_ff, ang_in;
   logic [4:0]                     i_ff, i_in;
   logic [CORDIC_WIDTH-1:0]        mx, my;
   logic signed [CORDIC_WIDTH-1:0] dx, dy;
   logic signed [ACC_WIDTH-1:0]    tab, clamped, rounded, shifted;

   always_comb begin
      mx  = x_ff[CORDIC_WIDTH-1] ? -x_ff : x_ff;
      my  = y_ff[CORDIC_WIDTH-1] ? -y_ff : y_ff;
      dx  = y_ff >>> i_ff;
      dy  = x_ff >>> i_ff;
      tab = $signed({{(ACC_WIDTH-30){1'b0}}, ATAN_TAB[i_ff]});
      phase_in = phase_ff;
      x_in_r   = x_ff;
      y_in_r   = y_ff;
      ang_in   = ang_ff;
      i_in     = i_ff;
      if (start) begin
         if (x_in == '0 && y_in == '0) begin
            ang_in   = '0;
            phase_in = PH_IDLE;
         end else if (x_in[CORDIC_WIDTH-1]) begin
            x_in_r   = -x_in;
            y_in_r   = -y_in;
            ang_in   = y_in[CORDIC_WIDTH-1] ? -PI_A : PI_A;
            phase_in = PH_NORM;
         end else begin
            x_in_r   = x_in;
            y_in_r   = y_in;
            ang_in   = '0;
            phase_in = PH_NORM;
         end
      end else begin
         unique case (phase_ff)
            PH_IDLE: begin
            end
            PH_NORM: begin
               if (mx < COARSE_LIMIT && my < COARSE_LIMIT) begin
                  x_in_r = x_ff <<< 8;
                  y_in_r = y_ff <<< 8;
               end else if (mx < NORM_LIMIT && my < NORM_LIMIT) begin
                  x_in_r = x_ff <<< 1;
                  y_in_r = y_ff <<< 1;
               end else begin
                  i_in     = '0;
                  phase_in = PH_ROT;
               end
            end
            PH_ROT: begin
               if (!y_ff[CORDIC_WIDTH-1]) begin
                  x_in_r = x_ff + dx;
                  y_in_r = y_ff - dy;
                  ang_in = ang_ff + tab;
               end else begin
                  x_in_r = x_ff - dx;
                  y_in_r = y_ff + dy;
                  ang_in = ang_ff - tab;
               end
               i_in = i_ff + 5'd1;
               if (i_ff == 5'(CORDIC_STEPS - 1)) begin
                  phase_in = PH_IDLE;
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in_r;
      y_ff   <= y_in_r;
      ang_ff <= ang_in;
      i_ff   <= i_in;
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_comb begin
      if (ang_ff > PI_A) begin
         clamped = PI_A;
      end else if (ang_ff < -PI_A) begin
         clamped = -PI_A;
      end else begin
         clamped = ang_ff;
      end
      rounded = clamped + RND_A;
      shifted = rounded >>> (30 - F);
   end

   assign idle   = phase_ff == PH_IDLE;
   assign result = shifted[F+2:0];
endmodule
`default_nettype wire

### hdl/c2s_datapath.sv
`default_nettype none
module c2s_datapath
   import c2s_pkg::*;
#(
   parameter int W = 20,
   parameter int F = 13
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic signed [W-1:0] req_x_mm,
   input  wire logic signed [W-1:0] req_y_mm,
   input  wire logic signed [W-1:0] req_z_mm,
   input  wire logic                req_first_point,
   input  wire cmd_type             cmd,
   output status_type               status,
   input  wire logic                rsp_stall,
   output logic                     rsp_valid,
   output logic [W-1:0]             rsp_range_mm,
   output logic [F+1:0]             rsp_polar_angle,
   output logic signed [F+5:0]      rsp_azimuth,
   output logic                     rsp_azimuth_saturated
);
   localparam int UW = F + 8;
   localparam int RXW = W + 24;
   localparam logic signed [UW-1:0] THP_U = UW'(to_frac(THREE_HALF_PI_Q30, F));
   localparam logic signed [UW-1:0] TP_U  = UW'(to_frac(TWO_PI_Q30, F));
   localparam logic signed [F+2:0]  PI_P  = (F+3)'(to_frac(PI_Q30, F));
   localparam logic signed [UW-1:0] AZ_MAX = UW'((longint'(1) <<< (F + 5)) - 1);
   localparam logic signed [UW-1:0] AZ_MIN = -UW'(longint'(1) <<< (F + 5));

   logic signed [W-1:0]  x_ff, y_ff, z_ff;
   logic                 first_ff;
   logic [W-1:0]         ax, ay, az;
   logic [2*W-1:0]       sq_x_ff, sq_y_ff, sq_z_ff, sxy_ff, sall_ff;
   logic signed [F+2:0]  phi_ff;
   logic signed [F+5:0]  prev_ff, az_in;
   logic                 valid_ff, sat_in;
   logic [W-1:0]         range_ff, range_in;
   logic [F+1:0]         polar_ff, polar_in;
   logic signed [F+5:0]  azimuth_ff;
   logic                 sat_ff;

   logic                 rng_idle, rxy_idle, cordic_idle;
   logic [W-1:0]         rng_root;
   logic [W+1:0]         rng_rem;
   logic [RXW-1:0]       rxy_root;
   logic [RXW+1:0]       rxy_rem;
   logic signed [CORDIC_WIDTH-1:0] cy, cx;
   logic signed [F+2:0]  ang;
   logic signed [UW-1:0] phi_w, prev_w, diff, unwr;

   always_comb begin
      ax = x_ff[W-1] ? -x_ff : x_ff;
      ay = y_ff[W-1] ? -y_ff : y_ff;
      az = z_ff[W-1] ? -z_ff : z_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff     <= req_x_mm;
         y_ff     <= req_y_mm;
         z_ff     <= req_z_mm;
         first_ff <= req_first_point;
      end
      if (cmd.square) begin
         sq_x_ff <= (2*W)'(ax) * (2*W)'(ax);
         sq_y_ff <= (2*W)'(ay) * (2*W)'(ay);
         sq_z_ff <= (2*W)'(az) * (2*W)'(az);
      end
      if (cmd.sum) begin
         sxy_ff  <= sq_x_ff + sq_y_ff;
         sall_ff <= sq_x_ff + sq_y_ff + sq_z_ff;
      end
      if (cmd.keep_az) begin
         phi_ff <= ang;
      end
   end

   c2s_sqrt #(.RW(2*W)) u_range_root (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start_root),
      .radicand (sall_ff),
      .idle     (rng_idle),
      .root     (rng_root),
      .rem      (rng_rem)
   );

   c2s_sqrt #(.RW(2*W+48)) u_planar_root (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start_root),
      .radicand ({sxy_ff, 48'd0}),
      .idle     (rxy_idle),
      .root     (rxy_root),
      .rem      (rxy_rem)
   );

   always_comb begin
      if (cmd.start_pol) begin
         cy = $signed({{(CORDIC_WIDTH-RXW){1'b0}}, rxy_root});
         cx = $signed({{(CORDIC_WIDTH-W){z_ff[W-1]}}, z_ff}) <<< 24;
      end else begin
         cy = $signed({{(CORDIC_WIDTH-W){y_ff[W-1]}}, y_ff});
         cx = $signed({{(CORDIC_WIDTH-W){x_ff[W-1]}}, x_ff});
      end
   end

   c2s_cordic #(.F(F)) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.start_az | cmd.start_pol),
      .y_in   (cy),
      .x_in   (cx),
      .idle   (cordic_idle),
      .result (ang)
   );

   // Range rounds up when the remainder exceeds the root.
   always_comb begin
      range_in = rng_root + W'(rng_rem > {2'b00, rng_root});
      if (ang[F+2]) begin
         polar_in = '0;
      end else if (ang > PI_P) begin
         polar_in = PI_P[F+1:0];
      end else begin
         polar_in = ang[F+1:0];
      end
      phi_w  = {{5{phi_ff[F+2]}}, phi_ff};
      prev_w = {{2{prev_ff[F+5]}}, prev_ff};
      diff   = phi_w - prev_w;
      unwr   = phi_w;
      if (!first_ff) begin
         if (diff > THP_U) begin
            unwr = phi_w - TP_U;
         end else if (diff < -THP_U) begin
            unwr = phi_w + TP_U;
         end
      end
      sat_in = 1'b0;
      az_in  = unwr[F+5:0];
      if (unwr > AZ_MAX) begin
         az_in  = AZ_MAX[F+5:0];
         sat_in = 1'b1;
      end else if (unwr < AZ_MIN) begin
         az_in  = AZ_MIN[F+5:0];
         sat_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         range_ff   <= range_in;
         polar_ff   <= polar_in;
         azimuth_ff <= az_in;
         sat_ff     <= sat_in;
      end
      if (reset) begin
         valid_ff <= 1'b0;
         prev_ff  <= '0;
      end else begin
         if (cmd.finish) begin
            valid_ff <= 1'b1;
            prev_ff  <= az_in;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      status.root_idle   = rng_idle & rxy_idle;
      status.cordic_idle = cordic_idle;
      status.out_free    = !valid_ff || !rsp_stall;
   end

   assign rsp_valid             = valid_ff;
   assign rsp_range_mm          = range_ff;
   assign rsp_polar_angle       = polar_ff;
   assign rsp_azimuth           = azimuth_ff;
   assign rsp_azimuth_saturated = sat_ff;
endmodule
`default_nettype wire

### hdl/c2s_ctrl.sv
`default_nettype none
module c2s_ctrl
   import c2s_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire status_type status,
   output cmd_type         cmd
);
   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_SQUARE   = 7'b0000010,
      ST_SUM      = 7'b0000100,
      ST_START    = 7'b0001000,
      ST_WAIT_AZ  = 7'b0010000,
      ST_POLAR    = 7'b0100000,
      ST_WAIT_POL = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_START;
         end
         ST_START: begin
            cmd.start_root = 1'b1;
            cmd.start_az   = 1'b1;
            state_in       = ST_WAIT_AZ;
         end
         ST_WAIT_AZ: begin
            if (status.root_idle && status.cordic_idle) begin
               cmd.keep_az = 1'b1;
               state_in    = ST_POLAR;
            end
         end
         ST_POLAR: begin
            cmd.start_pol = 1'b1;
            state_in      = ST_WAIT_POL;
         end
         ST_WAIT_POL: begin
            if (status.cordic_idle && status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;
endmodule
`default_nettype wire

### bench/cartesian_to_spherical_unwrap_checker.sv
`timescale 1ns / 1ps
module cartesian_to_spherical_unwrap_checker
   import c2s_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_stall,
   input  wire logic signed [19:0] req_x_mm,
   input  wire logic signed [19:0] req_y_mm,
   input  wire logic signed [19:0] req_z_mm,
   input  wire logic               req_first_point,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_stall,
   input  wire logic [19:0]        rsp_range_mm,
   input  wire logic [14:0]        rsp_polar_angle,
   input  wire logic signed [18:0] rsp_azimuth,
   input  wire logic               rsp_azimuth_saturated,
   output int                      failures,
   output int                      pending
);

   typedef struct packed {
      logic [19:0]        range_mm;
      logic [14:0]        polar;
      logic signed [18:0] azimuth;
      logic               saturated;
   } spherical_type;

   spherical_type       expected_points[$];
   logic signed [18:0]  last_azimuth;

   function automatic longint round_angle(input longint q30);
      return (q30 + 64'sd65536) >>> 17;
   endfunction

   function automatic logic [63:0] root_floor(input logic [127:0] n);
      logic [63:0]  r;
      logic [63:0]  t;
      logic [127:0] sq;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         t = r | (64'd1 << b);
         sq = {64'd0, t} * {64'd0, t};
         if (sq <= n) r = t;
      end
      return r;
   endfunction

   function automatic longint magnitude(input longint v);
      return v < 0 ? -v : v;
   endfunction

   // Vectoring CORDIC angle of (x, y) in Q.30 radians.
   function automatic longint cordic_angle(input longint y_in, input longint x_in);
      longint x, y, nx, base, acc, limit;
      x = x_in;
      y = y_in;
      base = 0;
      acc = 0;
      limit = longint'(1) <<< 57;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         base = (y >= 0) ? PI_Q30 : -PI_Q30;
         x = -x;
         y = -y;
      end
      while (magnitude(x) < limit && magnitude(y) < limit) begin
         x = x * 2;
         y = y * 2;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         nx = x;
         if (y >= 0) begin
            x = x + (y >>> i);
            y = y - (nx >>> i);
            acc = acc + longint'(ATAN_TAB[i]);
         end else begin
            x = x - (y >>> i);
            y = y + (nx >>> i);
            acc = acc - longint'(ATAN_TAB[i]);
         end
      end
      acc = acc + base;
      if (acc > PI_Q30) acc = PI_Q30;
      if (acc < -PI_Q30) acc = -PI_Q30;
      return acc;
   endfunction

   function automatic spherical_type convert_point(input logic signed [19:0] px,
         input logic signed [19:0] py, input logic signed [19:0] pz, input logic first);
      spherical_type res;
      longint x, y, z, planar_sq, total_sq, rng, planar, polar, phi, prev;
      longint pi_f, three_half, full_turn;
      x = longint'(px);
      y = longint'(py);
      z = longint'(pz);
      pi_f = round_angle(PI_Q30);
      three_half = round_angle(THREE_HALF_PI_Q30);
      full_turn = round_angle(TWO_PI_Q30);
      planar_sq = x * x + y * y;
      total_sq = planar_sq + z * z;
      rng = longint'(root_floor({64'd0, total_sq}));
      if (total_sq > rng * rng + rng) rng++;
      planar = longint'(root_floor({64'd0, planar_sq} << 48));
      polar = round_angle(cordic_angle(planar, z * 64'sd16777216));
      if (polar < 0) polar = 0;
      if (polar > pi_f) polar = pi_f;
      phi = round_angle(cordic_angle(y, x));
      if (!first) begin
         prev = longint'(last_azimuth);
         if (phi - prev > three_half) phi = phi - full_turn;
         else if (phi - prev < -three_half) phi = phi + full_turn;
      end
      res.saturated = 1'b0;
      if (phi > 262143) begin
         phi = 262143;
         res.saturated = 1'b1;
      end
      if (phi < -262144) begin
         phi = -262144;
         res.saturated = 1'b1;
      end
      last_azimuth = phi[18:0];
      res.range_mm = rng[19:0];
      res.polar = polar[14:0];
      res.azimuth = phi[18:0];
      return res;
   endfunction

   assign pending = expected_points.size();

   always @(posedge clock) begin
      spherical_type want;
      int bad;
      bad = 0;
      if (reset) begin
         last_azimuth <= '0;
         failures <= 0;
         expected_points.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               $display("%0t: result transfer with no point outstanding", $time);
               bad = bad + 1;
            end else begin
               want = expected_points.pop_front();
               if (want.range_mm !== rsp_range_mm) begin
                  $display("%0t: range expected %0d actual %0d", $time,
                     want.range_mm, rsp_range_mm);
                  bad = bad + 1;
               end
               if (want.polar !== rsp_polar_angle) begin
                  $display("%0t: polar expected %0d actual %0d", $time,
                     want.polar, rsp_polar_angle);
                  bad = bad + 1;
               end
               if (want.azimuth !== rsp_azimuth) begin
                  $display("%0t: azimuth expected %0d actual %0d", $time,
                     want.azimuth, rsp_azimuth);
                  bad = bad + 1;
               end
               if (want.saturated !== rsp_azimuth_saturated) begin
                  $display("%0t: saturation flag expected %0b actual %0b", $time,
                     want.saturated, rsp_azimuth_saturated);
                  bad = bad + 1;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_points.insert(expected_points.size(),
               convert_point(req_x_mm, req_y_mm, req_z_mm, req_first_point));
         failures <= failures + bad;
      end
   end

endmodule

### bench/cartesian_to_spherical_unwrap_tb.sv
`timescale 1ns / 1ps
module cartesian_to_spherical_unwrap_tb;

   // A watchdog ends the run after this many cycles without any transfer.
   // This bound is generous next to the time of one point plus a long
   // sender gap or receiver stall.
   localparam int IDLE_LIMIT = 5000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [19:0] req_x_mm = '0;
   logic signed [19:0] req_y_mm = '0;
   logic signed [19:0] req_z_mm = '0;
   logic               req_first_point = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [19:0]        rsp_range_mm;
   logic [14:0]        rsp_polar_angle;
   logic signed [18:0] rsp_azimuth;
   logic               rsp_azimuth_saturated;
   int                 failures;
   int                 pending;
   int                 idle_cycles = 0;
   // When clear, neither side inserts gaps, so back-to-back traffic is seen too.
   logic               idling_on = 1'b1;

   always #6 clock = ~clock;

   cartesian_to_spherical_unwrap DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_x_mm(req_x_mm), .req_y_mm(req_y_mm), .req_z_mm(req_z_mm),
      .req_first_point(req_first_point),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_range_mm(rsp_range_mm), .rsp_polar_angle(rsp_polar_angle),
      .rsp_azimuth(rsp_azimuth), .rsp_azimuth_saturated(rsp_azimuth_saturated)
   );

   cartesian_to_spherical_unwrap_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_x_mm(req_x_mm), .req_y_mm(req_y_mm), .req_z_mm(req_z_mm),
      .req_first_point(req_first_point),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_range_mm(rsp_range_mm), .rsp_polar_angle(rsp_polar_angle),
      .rsp_azimuth(rsp_azimuth), .rsp_azimuth_saturated(rsp_azimuth_saturated),
      .failures(failures), .pending(pending)
   );

   // Picks a gap length: mostly none or short, now and then a long one.
   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (!idling_on || pick < 55) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // The receiver stalls in bursts drawn the same way as the sender gaps.
   int stall_left = 0;
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         stall_left <= gap_length();
         rsp_stall <= 1'b0;
      end
   end

   // The watchdog counts cycles in which no transfer happens on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("cartesian_to_spherical_unwrap regression: fail");
         $finish;
      end
   end

   // Presents one point and holds it until the transfer happens. Valid stays
   // high into the next point unless a gap is drawn.
   task automatic send_point(input logic signed [19:0] x, input logic signed [19:0] y,
         input logic signed [19:0] z, input logic first);
      int gap;
      req_x_mm <= x;
      req_y_mm <= y;
      req_z_mm <= z;
      req_first_point <= first;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Returns a coordinate of random magnitude; small values are favored so
   // that near-axis and near-origin angles come up often.
   function automatic logic signed [19:0] any_coordinate();
      case ($urandom_range(0, 3))
         0: return 20'($urandom_range(0, 15) - 8);
         1: return 20'($urandom_range(0, 4095) - 2048);
         default: return 20'($urandom);
      endcase
   endfunction

   // Magnitude for a scan point, kept inside the positive field range.
   function automatic logic signed [19:0] scan_magnitude();
      return 20'($urandom_range(1, 524287));
   endfunction

   // A scan sweeps the four quadrants in order, so the azimuth can pass through
   // the negative x axis and the unwrapping logic then has to add or remove a turn.
   task automatic send_scan(input int points, input logic reverse);
      int quadrant;
      logic signed [19:0] x, y;
      quadrant = $urandom_range(0, 3);
      for (int k = 0; k < points; k++) begin
         x = scan_magnitude();
         y = scan_magnitude();
         case (quadrant)
            1: x = -x;
            2: begin
               x = -x;
               y = -y;
            end
            3: y = -y;
            default: ;
         endcase
         send_point(x, y, any_coordinate(), k == 0);
         if (($urandom_range(0, 2)) != 0)
            quadrant = reverse ? (quadrant + 3) % 4 : (quadrant + 1) % 4;
      end
   endtask

   initial begin
      int sent;
      int length;
      bit drained;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed points. The first one is not marked as a scan start, so it
      // unwraps against the zero left by reset.
      send_point(-20'sd1000, 20'sd0, 20'sd5, 1'b0);
      send_point(20'sd0, 20'sd0, 20'sd0, 1'b1);
      send_point(20'sd0, 20'sd0, 20'sd0, 1'b0);
      send_point(-20'sd524288, -20'sd524288, -20'sd524288, 1'b1);
      send_point(20'sd524287, 20'sd524287, 20'sd524287, 1'b0);
      send_point(-20'sd524288, 20'sd0, 20'sd0, 1'b0);
      send_point(-20'sd1, 20'sd0, 20'sd0, 1'b0);
      send_point(-20'sd524288, -20'sd1, 20'sd0, 1'b0);
      send_point(-20'sd524288, 20'sd1, 20'sd0, 1'b0);
      send_point(-20'sd524288, -20'sd1, 20'sd0, 1'b0);
      send_point(20'sd0, 20'sd0, 20'sd524287, 1'b0);
      send_point(20'sd0, 20'sd0, -20'sd524288, 1'b0);
      send_point(20'sd0, 20'sd524287, 20'sd1, 1'b0);
      send_point(20'sd0, -20'sd524288, -20'sd1, 1'b0);
      send_point(20'sd1, 20'sd0, 20'sd0, 1'b0);
      send_point(20'sd3, 20'sd4, 20'sd12, 1'b1);
      send_point(-20'sd3, 20'sd4, 20'sd0, 1'b0);
      send_point(-20'sd3, -20'sd4, 20'sd0, 1'b0);
      send_point(-20'sd524288, 20'sd524287, -20'sd524288, 1'b0);

      // Random part: mostly scans that sweep the azimuth around the circle,
      // mixed with unrelated points.
      sent = 0;
      drained = 1'b0;
      while (sent < 900) begin
         if (!drained && sent >= 450) begin
            // The sender holds off until the block has drained completely.
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
            drained = 1'b1;
         end
         idling_on <= ($urandom_range(0, 4) != 0);
         if ($urandom_range(0, 3) == 0) begin
            length = $urandom_range(1, 10);
            for (int k = 0; k < length; k++)
               send_point(any_coordinate(), any_coordinate(), any_coordinate(),
                  1'($urandom_range(0, 1)));
         end else begin
            length = $urandom_range(4, 30);
            send_scan(length, 1'($urandom_range(0, 1)));
         end
         sent += length;
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (failures == 0)
         $display("cartesian_to_spherical_unwrap regression: pass");
      else
         $display("cartesian_to_spherical_unwrap regression: fail");
      $finish;
   end

endmodule
